>>> src/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// shared implication checks for the rtl assertions
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define CHK_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("check failed");

// next-cycle implication
`define CHK_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("check failed");

`endif

>>> src/rbgc_pkg.sv
// ----------------------------------------------------------------------------
// rbgc_pkg
// types, constants and helpers of the rigid body ground contact step
// ----------------------------------------------------------------------------
`default_nettype none

package rbgc_pkg;

   localparam int MaxBodies = 64;
   localparam int FracBits  = 16;
   localparam longint OneQ  = longint'(1) << FracBits;
   localparam longint DampQ = (95 * OneQ + 50) / 100;
   localparam longint SnapQ = (OneQ + 50) / 100;
   localparam logic [63:0] Snap2 = 64'(SnapQ * SnapQ);

   localparam logic [2:0] CMD_STEP   = 3'd0;
   localparam logic [2:0] CMD_FORCE  = 3'd1;
   localparam logic [2:0] CMD_FORCDT = 3'd2;
   localparam logic [2:0] CMD_TORQUE = 3'd3;
   localparam logic [2:0] CMD_LOAD   = 3'd4;

   localparam logic REG_MASS = 1'b0;
   localparam logic REG_GRAV = 1'b1;

   typedef struct packed {
      logic [2:0]         command;
      logic [5:0]         body_index;
      logic [30:0]        time_step;
      logic signed [31:0] force_x;
      logic signed [31:0] force_y;
      logic signed [31:0] force_z;
      logic signed [31:0] point_x;
      logic signed [31:0] point_y;
      logic signed [31:0] point_z;
   } req_type;

   typedef struct packed {
      logic [5:0]         body_out;
      logic signed [31:0] pos_x_out;
      logic signed [31:0] pos_y_out;
      logic signed [31:0] pos_z_out;
      logic signed [31:0] rot_x_out;
      logic signed [31:0] rot_y_out;
      logic signed [31:0] rot_z_out;
      logic               ground_contact;
   } rsp_type;

   typedef struct packed {
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] pos_z;
      logic signed [31:0] vel_x;
      logic signed [31:0] vel_y;
      logic signed [31:0] vel_z;
      logic signed [31:0] spin_x;
      logic signed [31:0] spin_y;
      logic signed [31:0] spin_z;
      logic signed [31:0] rot_x;
      logic signed [31:0] rot_y;
      logic signed [31:0] rot_z;
   } body_rec_type;

   function automatic logic signed [63:0] sx64(input logic signed [31:0] v);
      return {{32{v[31]}}, v};
   endfunction

   function automatic logic signed [33:0] sx34(input logic signed [31:0] v);
      return {{2{v[31]}}, v};
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
      if (v > 64'sh0000_0000_7FFF_FFFF) begin
         return 32'sh7FFF_FFFF;
      end else if (v < -64'sh0000_0000_8000_0000) begin
         return 32'sh8000_0000;
      end
      return v[31:0];
   endfunction

   function automatic logic signed [31:0] addsat(input logic signed [31:0] a,
                                                 input logic signed [63:0] b);
      return sat32(sx64(a) + b);
   endfunction

endpackage

`default_nettype wire

>>> src/rigid_body_ground_contact_step.sv
// ----------------------------------------------------------------------------
// rigid_body_ground_contact_step
// per-body semi-implicit euler step with ground contact, q16.16 fixed point
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low; busy stays high until
// the body record is written back. The result appears on rsp_data in the
// cycle after the write-back, for exactly one cycle, marked by rsp_valid,
// and cannot be stalled. Each item goes through the read of the record,
// then a micro-sequence through one shared 34x34 multiplier, then
// write-back. Add force, load and unused commands do not use the multiplier;
// a step in the air skips the ground force, spin damping and spin snap.
// The body table (64 records of 384 bits) lives in one synchronous ram;
// a valid flop per body makes never-written records read as zero.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module rigid_body_ground_contact_step
   import rbgc_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   // item channel
   input  wire logic        start,
   output logic             busy,
   input  wire req_type     req_data,
   // result channel
   output logic             rsp_valid,
   output rsp_type          rsp_data,
   // register port
   input  wire logic        psel,
   input  wire logic        penable,
   input  wire logic        pwrite,
   input  wire logic [2:0]  paddr,
   input  wire logic [31:0] pwdata,
   output logic [31:0]      prdata,
   output logic             pready
);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_READ  = 2'd1;
   localparam logic [1:0] ST_EXEC  = 2'd2;
   localparam logic [1:0] ST_WRITE = 2'd3;

   localparam int RecW = $bits(body_rec_type);

   logic [1:0]           state_ff, state_in;
   logic [4:0]           step_ff, step_in;
   req_type              item_ff, item_in;
   body_rec_type         rec_ff, rec_in;
   logic [MaxBodies-1:0] valid_ff, valid_in;
   logic signed [67:0]   prod_ff, prod_in;
   logic signed [31:0]   g_ff, g_in;
   logic signed [63:0]   t_ff, t_in;
   logic [63:0]          s2_ff, s2_in;
   logic                 contact_ff, contact_in;
   logic [30:0]          mass_ff, grav_ff;
   rsp_type              rsp_ff, rsp_in;
   logic                 rsp_valid_ff, rsp_valid_in;

   logic signed [33:0]   mul_a, mul_b;
   logic                 ram_we;
   logic [5:0]           ram_raddr;
   logic [RecW-1:0]      ram_rdata;

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign pready    = 1'b1;
   assign prdata    = (paddr[2] == REG_GRAV) ? {1'b0, grav_ff} : {1'b0, mass_ff};
   assign prod_in   = mul_a * mul_b;
   assign ram_raddr = (state_ff == ST_IDLE) ? req_data.body_index : item_ff.body_index;

   rbgc_ram #(.Width(RecW), .Depth(MaxBodies)) u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (item_ff.body_index),
      .wdata (rec_ff),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   // sequencer
   always_comb begin
      logic signed [67:0] sh;
      logic signed [63:0] sc;
      logic signed [31:0] g, imp;
      logic signed [32:0] av, rx, ry, rz;
      state_in     = state_ff;
      step_in      = step_ff;
      item_in      = item_ff;
      rec_in       = rec_ff;
      valid_in     = valid_ff;
      g_in         = g_ff;
      t_in         = t_ff;
      s2_in        = s2_ff;
      contact_in   = contact_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = 1'b0;
      ram_we       = 1'b0;
      mul_a        = '0;
      mul_b        = '0;
      // floor-scaled product of the previous cycle
      sh  = prod_ff >>> FracBits;
      sc  = sh[63:0];
      g   = sat32(sc);
      imp = sat32(sc);
      av  = rec_ff.vel_y[31] ? -{rec_ff.vel_y[31], rec_ff.vel_y}
                             : {rec_ff.vel_y[31], rec_ff.vel_y};
      // lever arm for torque
      rx  = {item_ff.point_x[31], item_ff.point_x} - {rec_ff.pos_x[31], rec_ff.pos_x};
      ry  = {item_ff.point_y[31], item_ff.point_y} - {rec_ff.pos_y[31], rec_ff.pos_y};
      rz  = {item_ff.point_z[31], item_ff.point_z} - {rec_ff.pos_z[31], rec_ff.pos_z};

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               item_in    = req_data;
               contact_in = 1'b0;
               state_in   = ST_READ;
            end
         end
         ST_READ: begin
            rec_in   = valid_ff[item_ff.body_index] ? body_rec_type'(ram_rdata) : '0;
            step_in  = '0;
            state_in = ST_EXEC;
         end
         ST_EXEC: begin
            step_in = step_ff + 5'd1;
            case (item_ff.command)
               CMD_STEP: begin
                  case (step_ff)
                     5'd0: begin
                        mul_a = {3'b0, mass_ff};
                        mul_b = {3'b0, grav_ff};
                     end
                     5'd1: begin
                        // gravity, then ground test on the old height
                        g_in         = g;
                        rec_in.vel_y = sat32(sx64(rec_ff.vel_y) - sx64(g));
                        contact_in   = (rec_ff.pos_y <= 0);
                     end
                     5'd2: begin
                        mul_a = {3'b0, mass_ff};
                        mul_b = {av[32], av};
                        if (!contact_ff) begin
                           step_in = 5'd11;
                        end
                     end
                     5'd3: begin
                        // normal force
                        rec_in.vel_y = addsat(rec_ff.vel_y,
                                              sx64(sat32(sx64(g_ff) + sx64(imp))));
                        mul_a = sx34(rec_ff.spin_x);
                        mul_b = 34'(DampQ);
                     end
                     5'd4: begin
                        rec_in.spin_x = sat32(sc);
                        mul_a = sx34(rec_ff.spin_y);
                        mul_b = 34'(DampQ);
                     end
                     5'd5: begin
                        rec_in.spin_y = sat32(sc);
                        mul_a = sx34(rec_ff.spin_z);
                        mul_b = 34'(DampQ);
                     end
                     5'd6: begin
                        rec_in.spin_z = sat32(sc);
                        mul_a = sx34(rec_ff.spin_x);
                        mul_b = sx34(rec_ff.spin_x);
                     end
                     5'd7: begin
                        s2_in = prod_ff[63:0];
                        mul_a = sx34(rec_ff.spin_y);
                        mul_b = sx34(rec_ff.spin_y);
                     end
                     5'd8: begin
                        s2_in = s2_ff + prod_ff[63:0];
                        mul_a = sx34(rec_ff.spin_z);
                        mul_b = sx34(rec_ff.spin_z);
                     end
                     5'd9: begin
                        s2_in = s2_ff + prod_ff[63:0];
                     end
                     5'd10: begin
                        // snap small spin to rest
                        if (s2_ff < Snap2) begin
                           rec_in.spin_x = '0;
                           rec_in.spin_y = '0;
                           rec_in.spin_z = '0;
                        end
                     end
                     5'd11: begin
                        mul_a = sx34(rec_ff.vel_x);
                        mul_b = {3'b0, item_ff.time_step};
                     end
                     5'd12: begin
                        rec_in.pos_x = addsat(rec_ff.pos_x, sc);
                        mul_a = sx34(rec_ff.vel_y);
                        mul_b = {3'b0, item_ff.time_step};
                     end
                     5'd13: begin
                        rec_in.pos_y = addsat(rec_ff.pos_y, sc);
                        mul_a = sx34(rec_ff.vel_z);
                        mul_b = {3'b0, item_ff.time_step};
                     end
                     5'd14: begin
                        rec_in.pos_z = addsat(rec_ff.pos_z, sc);
                        mul_a = sx34(rec_ff.spin_x);
                        mul_b = {3'b0, item_ff.time_step};
                     end
                     5'd15: begin
                        rec_in.rot_x = addsat(rec_ff.rot_x, sc);
                        mul_a = sx34(rec_ff.spin_y);
                        mul_b = {3'b0, item_ff.time_step};
                     end
                     5'd16: begin
                        rec_in.rot_y = addsat(rec_ff.rot_y, sc);
                        mul_a = sx34(rec_ff.spin_z);
                        mul_b = {3'b0, item_ff.time_step};
                     end
                     default: begin
                        rec_in.rot_z = addsat(rec_ff.rot_z, sc);
                        state_in     = ST_WRITE;
                     end
                  endcase
               end
               CMD_FORCE: begin
                  rec_in.vel_x = addsat(rec_ff.vel_x, sx64(item_ff.force_x));
                  rec_in.vel_y = addsat(rec_ff.vel_y, sx64(item_ff.force_y));
                  rec_in.vel_z = addsat(rec_ff.vel_z, sx64(item_ff.force_z));
                  state_in     = ST_WRITE;
               end
               CMD_FORCDT: begin
                  mul_b = {3'b0, item_ff.time_step};
                  case (step_ff)
                     5'd0: mul_a = sx34(item_ff.force_x);
                     5'd1: begin
                        rec_in.vel_x = addsat(rec_ff.vel_x, sc);
                        mul_a = sx34(item_ff.force_y);
                     end
                     5'd2: begin
                        rec_in.vel_y = addsat(rec_ff.vel_y, sc);
                        mul_a = sx34(item_ff.force_z);
                     end
                     default: begin
                        rec_in.vel_z = addsat(rec_ff.vel_z, sc);
                        state_in     = ST_WRITE;
                     end
                  endcase
               end
               CMD_TORQUE: begin
                  // each cross term scaled on its own, then differenced
                  case (step_ff)
                     5'd0: begin
                        mul_a = {ry[32], ry};
                        mul_b = sx34(item_ff.force_z);
                     end
                     5'd1: begin
                        t_in  = sc;
                        mul_a = {rz[32], rz};
                        mul_b = sx34(item_ff.force_y);
                     end
                     5'd2: begin
                        rec_in.spin_x = addsat(rec_ff.spin_x, sx64(sat32(t_ff - sc)));
                        mul_a = {rz[32], rz};
                        mul_b = sx34(item_ff.force_x);
                     end
                     5'd3: begin
                        t_in  = sc;
                        mul_a = {rx[32], rx};
                        mul_b = sx34(item_ff.force_z);
                     end
                     5'd4: begin
                        rec_in.spin_y = addsat(rec_ff.spin_y, sx64(sat32(t_ff - sc)));
                        mul_a = {rx[32], rx};
                        mul_b = sx34(item_ff.force_y);
                     end
                     5'd5: begin
                        t_in  = sc;
                        mul_a = {ry[32], ry};
                        mul_b = sx34(item_ff.force_x);
                     end
                     default: begin
                        rec_in.spin_z = addsat(rec_ff.spin_z, sx64(sat32(t_ff - sc)));
                        state_in      = ST_WRITE;
                     end
                  endcase
               end
               CMD_LOAD: begin
                  rec_in       = '0;
                  rec_in.pos_x = item_ff.point_x;
                  rec_in.pos_y = item_ff.point_y;
                  rec_in.pos_z = item_ff.point_z;
                  state_in     = ST_WRITE;
               end
               default: begin
                  state_in = ST_WRITE;
               end
            endcase
         end
         default: begin
            // write back and report
            ram_we                          = 1'b1;
            valid_in[item_ff.body_index]    = 1'b1;
            rsp_in.body_out                 = item_ff.body_index;
            rsp_in.pos_x_out                = rec_ff.pos_x;
            rsp_in.pos_y_out                = rec_ff.pos_y;
            rsp_in.pos_z_out                = rec_ff.pos_z;
            rsp_in.rot_x_out                = rec_ff.rot_x;
            rsp_in.rot_y_out                = rec_ff.rot_y;
            rsp_in.rot_z_out                = rec_ff.rot_z;
            rsp_in.ground_contact           = (item_ff.command == CMD_STEP) && contact_ff;
            rsp_valid_in                    = 1'b1;
            state_in                        = ST_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         mass_ff      <= 31'd65536;
         grav_ff      <= 31'd642908;
      end else begin
         state_ff     <= state_in;
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (psel && penable && pwrite) begin
            if (paddr[2] == REG_GRAV) begin
               grav_ff <= pwdata[30:0];
            end else begin
               mass_ff <= pwdata[30:0];
            end
         end
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      step_ff    <= step_in;
      item_ff    <= item_in;
      rec_ff     <= rec_in;
      prod_ff    <= prod_in;
      g_ff       <= g_in;
      t_ff       <= t_in;
      s2_ff      <= s2_in;
      contact_ff <= contact_in;
      rsp_ff     <= rsp_in;
   end

   `CHK_NEXT(a_accept_reads, clock, reset, start && !busy, state_ff == ST_READ)
   `CHK_NEXT(a_write_reports, clock, reset, state_ff == ST_WRITE, rsp_valid)
   `CHK_SAME(a_report_idle, clock, reset, rsp_valid, state_ff == ST_IDLE)
   `CHK_SAME(a_contact_step, clock, reset, rsp_valid && rsp_data.ground_contact,
             item_ff.command == CMD_STEP)

endmodule

`default_nettype wire

>>> src/rbgc_ram.sv
// ----------------------------------------------------------------------------
// rbgc_ram
// simple dual port synchronous ram (one write, one read port), registered read
// ----------------------------------------------------------------------------
`default_nettype none

module rbgc_ram #(
   parameter int Width = 32,
   parameter int Depth = 64
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(Depth)-1:0] waddr,
   input  wire logic [Width-1:0]         wdata,
   input  wire logic [$clog2(Depth)-1:0] raddr,
   output logic      [Width-1:0]         rdata
);

   logic [Width-1:0] mem [Depth];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule

`default_nettype wire
